### hdl/banked_rom_mapper_with_scanline_irq_macros.svh
// Assertion macros for the banked ROM mapper.
// Included by bmap_back, the module that carries assertions; depends on nothing else.
`ifndef BANKED_ROM_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`define BANKED_ROM_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`ifndef SYNTHESIS
`define BMAP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmap assertion failed");
`define BMAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmap assertion failed");
`else
`define BMAP_ASSERT_NOW(label, clk, rst, ante, cons)
`define BMAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/bmap_pkg.sv
// Shared types and constants of the banked ROM mapper.
// Used by the front end, the queue, the back end, the top level and the testbench.
package bmap_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_PRG   = 2'd1,
      OP_CHR   = 2'd2,
      OP_TICK  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_SELECT  = 3'd0,
      REG_BANK    = 3'd1,
      REG_MIRROR  = 3'd2,
      REG_UNUSED  = 3'd3,
      REG_LATCH   = 3'd4,
      REG_RELOAD  = 3'd5,
      REG_IRQ_OFF = 3'd6,
      REG_IRQ_ON  = 3'd7
   } reg_code_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_PRG  = 2'd1,
      KIND_CHR  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  bank;
      logic [8:0]  count;
      logic [12:0] offset;
      logic        mirror;
      logic        irq;
   } entry_type;

   localparam int ADDRESS_WIDTH  = 15;
   localparam int DATA_WIDTH     = 8;
   localparam int OFFSET_WIDTH   = 19;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 9;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRG_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHR_COUNT = 1'b1;

   localparam logic [6:0] PRG_COUNT_RESET = 7'd2;
   localparam logic [8:0] CHR_COUNT_RESET = 9'd8;
   localparam logic [6:0] PRG_COUNT_MAX   = 7'd64;
   localparam logic [8:0] CHR_COUNT_MAX   = 9'd256;

endpackage

### hdl/bmap_front.sv
// Front end of the banked ROM mapper: takes request words, applies register writes and ticks,
// and picks the bank of each translation. Depends on bmap_pkg.
module bmap_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic [1:0]                              req_opcode,
   input  logic [bmap_pkg::ADDRESS_WIDTH-1:0]      req_address,
   input  logic [bmap_pkg::DATA_WIDTH-1:0]         req_write_data,
   input  logic                                    csr_write_enable,
   input  logic [bmap_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bmap_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  logic                                    queue_full,
   output logic                                    push,
   output bmap_pkg::entry_type                     push_data
);

   logic [6:0] prg_count_ff, prg_count_in;
   logic [8:0] chr_count_ff, chr_count_in;
   logic [2:0] select_ff, select_in;
   logic       prg_mode_ff, prg_mode_in;
   logic       chr_mode_ff, chr_mode_in;
   logic [7:0] bank_regs_ff [8];
   logic [7:0] bank_regs_in [8];
   logic [7:0] latch_ff, latch_in;
   logic [7:0] irq_count_ff, irq_count_in;
   logic       irq_enable_ff, irq_enable_in;
   logic       reload_ff, reload_in;
   logic       mirror_ff, mirror_in;

   logic [6:0] prg_n;
   logic [8:0] chr_n;
   logic [7:0] prg_second;
   logic [7:0] prg_last;
   logic [7:0] prg_r6;
   logic [7:0] prg_r7;
   logic       chr_half;
   logic [2:0] chr_index;
   logic [7:0] chr_reg;
   bmap_pkg::reg_code_type reg_code;

   always_comb begin
      if (prg_count_ff == 7'd0) begin
         prg_n = 7'd1;
      end else if (prg_count_ff > bmap_pkg::PRG_COUNT_MAX) begin
         prg_n = bmap_pkg::PRG_COUNT_MAX;
      end else begin
         prg_n = prg_count_ff;
      end
      if (chr_count_ff == 9'd0) begin
         chr_n = 9'd1;
      end else if (chr_count_ff > bmap_pkg::CHR_COUNT_MAX) begin
         chr_n = bmap_pkg::CHR_COUNT_MAX;
      end else begin
         chr_n = chr_count_ff;
      end
      prg_second = {1'b0, prg_n} - 8'd2;
      prg_last   = {1'b0, prg_n} - 8'd1;
      prg_r6     = {2'b00, bank_regs_ff[6][5:0]};
      prg_r7     = {2'b00, bank_regs_ff[7][5:0]};
      chr_half   = req_address[12] ^ chr_mode_ff;
      if (chr_half) begin
         chr_index = 3'd2 + {1'b0, req_address[11:10]};
      end else begin
         chr_index = {2'b00, req_address[11]};
      end
      chr_reg  = bank_regs_ff[chr_index];
      reg_code = bmap_pkg::reg_code_type'({req_address[14:13], req_address[0]});
   end

   always_comb begin
      prg_count_in  = prg_count_ff;
      chr_count_in  = chr_count_ff;
      select_in     = select_ff;
      prg_mode_in   = prg_mode_ff;
      chr_mode_in   = chr_mode_ff;
      bank_regs_in  = bank_regs_ff;
      latch_in      = latch_ff;
      irq_count_in  = irq_count_ff;
      irq_enable_in = irq_enable_ff;
      reload_in     = reload_ff;
      mirror_in     = mirror_ff;
      push          = req_valid && !queue_full;
      push_data     = '0;
      push_data.kind = bmap_pkg::KIND_NONE;

      if (csr_write_enable) begin
         case (csr_index)
            bmap_pkg::CSR_PRG_COUNT: prg_count_in = csr_write_data[6:0];
            bmap_pkg::CSR_CHR_COUNT: chr_count_in = csr_write_data;
            default: ;
         endcase
      end

      if (push) begin
         case (bmap_pkg::opcode_type'(req_opcode))
            bmap_pkg::OP_WRITE: begin
               case (reg_code)
                  bmap_pkg::REG_SELECT: begin
                     select_in   = req_write_data[2:0];
                     prg_mode_in = req_write_data[6];
                     chr_mode_in = req_write_data[7];
                  end
                  bmap_pkg::REG_BANK:    bank_regs_in[select_ff] = req_write_data;
                  bmap_pkg::REG_MIRROR:  mirror_in = req_write_data[0];
                  bmap_pkg::REG_UNUSED:  ;
                  bmap_pkg::REG_LATCH:   latch_in = req_write_data;
                  bmap_pkg::REG_RELOAD:  reload_in = 1'b1;
                  bmap_pkg::REG_IRQ_OFF: irq_enable_in = 1'b0;
                  bmap_pkg::REG_IRQ_ON:  irq_enable_in = 1'b1;
                  default: ;
               endcase
            end
            bmap_pkg::OP_PRG: begin
               push_data.kind   = bmap_pkg::KIND_PRG;
               push_data.count  = {2'b00, prg_n};
               push_data.offset = req_address[12:0];
               case (req_address[14:13])
                  2'd0:    push_data.bank = prg_mode_ff ? prg_second : prg_r6;
                  2'd1:    push_data.bank = prg_r7;
                  2'd2:    push_data.bank = prg_mode_ff ? prg_r6 : prg_second;
                  default: push_data.bank = prg_last;
               endcase
            end
            bmap_pkg::OP_CHR: begin
               push_data.kind   = bmap_pkg::KIND_CHR;
               push_data.count  = chr_n;
               push_data.offset = {3'b000, req_address[9:0]};
               push_data.bank   = chr_half ? chr_reg : {chr_reg[7:1], req_address[10]};
            end
            default: begin
               if (irq_count_ff == 8'd0 || reload_ff) begin
                  irq_count_in = latch_ff;
                  reload_in    = 1'b0;
               end else begin
                  irq_count_in = irq_count_ff - 8'd1;
               end
               push_data.irq = (irq_count_in == 8'd0) && irq_enable_ff;
            end
         endcase
      end
      push_data.mirror = mirror_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff  <= bmap_pkg::PRG_COUNT_RESET;
         chr_count_ff  <= bmap_pkg::CHR_COUNT_RESET;
         select_ff     <= 3'd0;
         prg_mode_ff   <= 1'b0;
         chr_mode_ff   <= 1'b0;
         bank_regs_ff  <= '{default: 8'd0};
         latch_ff      <= 8'd0;
         irq_count_ff  <= 8'd0;
         irq_enable_ff <= 1'b0;
         reload_ff     <= 1'b0;
         mirror_ff     <= 1'b1;
      end else begin
         prg_count_ff  <= prg_count_in;
         chr_count_ff  <= chr_count_in;
         select_ff     <= select_in;
         prg_mode_ff   <= prg_mode_in;
         chr_mode_ff   <= chr_mode_in;
         bank_regs_ff  <= bank_regs_in;
         latch_ff      <= latch_in;
         irq_count_ff  <= irq_count_in;
         irq_enable_ff <= irq_enable_in;
         reload_ff     <= reload_in;
         mirror_ff     <= mirror_in;
      end
   end

endmodule

### hdl/bmap_queue.sv
// Two-word queue between the front end and the back end of the mapper.
// Holds bmap_pkg::entry_type words; depends on bmap_pkg.
module bmap_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bmap_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output bmap_pkg::entry_type pop_data,
   output logic                empty
);

   bmap_pkg::entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### hdl/bmap_back.sv
// Back end of the mapper: reduces the bank modulo the bank count one bit per cycle
// and holds the result word for the consumer. Depends on bmap_pkg and the macro header.
`include "banked_rom_mapper_with_scanline_irq_macros.svh"

module bmap_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                queue_empty,
   input  bmap_pkg::entry_type                 pop_data,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bmap_pkg::OFFSET_WIDTH-1:0]   rsp_rom_offset,
   output logic                                rsp_mirror_horizontal,
   output logic                                rsp_irq_request
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_DONE
   } state_type;

   state_type         state_ff;
   bmap_pkg::kind_type kind_ff;
   logic [7:0]        bank_ff;
   logic [8:0]        count_ff;
   logic [8:0]        rem_ff;
   logic [12:0]       offset_ff;
   logic              mirror_ff;
   logic              irq_ff;
   logic [2:0]        step_ff;
   logic              rsp_valid_ff;
   logic [bmap_pkg::OFFSET_WIDTH-1:0] rsp_offset_ff;
   logic              rsp_mirror_ff;
   logic              rsp_irq_ff;

   logic [9:0]  shifted;
   logic [9:0]  trial;
   logic [8:0]  rem_in;
   logic        out_free;
   logic [bmap_pkg::OFFSET_WIDTH-1:0] offset_in;

   assign pop                   = (state_ff == S_IDLE) && !queue_empty;
   assign out_free              = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rom_offset        = rsp_offset_ff;
   assign rsp_mirror_horizontal = rsp_mirror_ff;
   assign rsp_irq_request       = rsp_irq_ff;

   always_comb begin
      shifted = {rem_ff, bank_ff[7]};
      trial   = shifted - {1'b0, count_ff};
      rem_in  = (shifted >= {1'b0, count_ff}) ? trial[8:0] : shifted[8:0];
      case (kind_ff)
         bmap_pkg::KIND_PRG: offset_in = {rem_ff[5:0], offset_ff};
         bmap_pkg::KIND_CHR: offset_in = {1'b0, rem_ff[7:0], offset_ff[9:0]};
         default:            offset_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  kind_ff   <= pop_data.kind;
                  bank_ff   <= pop_data.bank;
                  count_ff  <= pop_data.count;
                  offset_ff <= pop_data.offset;
                  mirror_ff <= pop_data.mirror;
                  irq_ff    <= pop_data.irq;
                  rem_ff    <= 9'd0;
                  step_ff   <= 3'd0;
                  state_ff  <= (pop_data.kind == bmap_pkg::KIND_NONE) ? S_DONE : S_DIV;
               end
            end
            S_DIV: begin
               rem_ff  <= rem_in;
               bank_ff <= {bank_ff[6:0], 1'b0};
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_offset_ff <= offset_in;
                  rsp_mirror_ff <= mirror_ff;
                  rsp_irq_ff    <= irq_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BMAP_ASSERT_NOW(a_div_has_map_kind, clock, reset, state_ff == S_DIV, kind_ff != bmap_pkg::KIND_NONE)
   `BMAP_ASSERT_NOW(a_rem_below_count, clock, reset, state_ff == S_DIV, rem_ff < count_ff)
   `BMAP_ASSERT_NEXT(a_pop_starts_work, clock, reset, pop, state_ff == S_DIV || state_ff == S_DONE)

endmodule

### hdl/banked_rom_mapper_with_scanline_irq.sv
// Banked ROM mapper with scanline interrupt counter: top level.
// A register write or a scanline tick skips the division and goes straight to its result word; a program
// or character translation waits on the bit-serial remainder unit in the back end, which reduces the
// 8-bit bank modulo the bank count in eight steps and works on one word at a time. Request words are
// taken into a two-word queue, so up to four words may be in flight while a result waits on rsp_stall.
// Depends on bmap_pkg, bmap_front, bmap_queue and bmap_back.
module banked_rom_mapper_with_scanline_irq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic [bmap_pkg::ADDRESS_WIDTH-1:0]    req_address,
   input  logic [bmap_pkg::DATA_WIDTH-1:0]       req_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bmap_pkg::OFFSET_WIDTH-1:0]     rsp_rom_offset,
   output logic                                  rsp_mirror_horizontal,
   output logic                                  rsp_irq_request,
   input  logic                                  csr_write_enable,
   input  logic [bmap_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bmap_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   logic                queue_full;
   logic                queue_empty;
   logic                push;
   logic                pop;
   bmap_pkg::entry_type push_data;
   bmap_pkg::entry_type pop_data;

   assign req_stall = queue_full;

   bmap_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_opcode       (req_opcode),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_data        (push_data)
   );

   bmap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   bmap_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .queue_empty           (queue_empty),
      .pop_data              (pop_data),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_rom_offset        (rsp_rom_offset),
      .rsp_mirror_horizontal (rsp_mirror_horizontal),
      .rsp_irq_request       (rsp_irq_request)
   );

endmodule

### tb/banked_rom_mapper_with_scanline_irq_tb.sv
// Self-checking testbench for the banked ROM mapper with scanline interrupt counter.
// A directed table, then random register, map and tick words under several bank counts,
// are checked against a predictor of the mapper. Depends on bmap_pkg and the mapper top level.
module banked_rom_mapper_with_scanline_irq_tb;
   import bmap_pkg::*;

   typedef struct packed {
      logic [OFFSET_WIDTH-1:0] rom_offset;
      logic                    mirror_horizontal;
      logic                    irq_request;
   } outcome_type;

   typedef struct packed {
      opcode_type              op;
      logic [ADDRESS_WIDTH-1:0] address;
      logic [DATA_WIDTH-1:0]   data;
      logic                    typed;
      outcome_type             want;
   } vector_type;

   localparam int DIRECTED_COUNT = 25;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_WORDS    = 128;
   localparam int IDLE_LIMIT     = 4000;
   localparam int TAIL_CYCLES    = 20;

   localparam vector_type DIRECTED [DIRECTED_COUNT] = '{
      '{OP_PRG,   15'h0000, 8'h00, 1'b1, '{19'h00000, 1'b1, 1'b0}},
      '{OP_PRG,   15'h7FFF, 8'hFF, 1'b1, '{19'h03FFF, 1'b1, 1'b0}},
      '{OP_CHR,   15'h0000, 8'h00, 1'b1, '{19'h00000, 1'b1, 1'b0}},
      '{OP_CHR,   15'h7FFF, 8'hFF, 1'b1, '{19'h003FF, 1'b1, 1'b0}},
      '{OP_TICK,  15'h7FFF, 8'hFF, 1'b1, '{19'h00000, 1'b1, 1'b0}},
      '{OP_WRITE, 15'h2000, 8'h00, 1'b1, '{19'h00000, 1'b0, 1'b0}},
      '{OP_WRITE, 15'h2001, 8'hFF, 1'b1, '{19'h00000, 1'b0, 1'b0}},
      '{OP_WRITE, 15'h0000, 8'h06, 1'b0, '0},
      '{OP_WRITE, 15'h1FFF, 8'hFF, 1'b0, '0},
      '{OP_PRG,   15'h0000, 8'h00, 1'b0, '0},
      '{OP_WRITE, 15'h0002, 8'hC7, 1'b0, '0},
      '{OP_WRITE, 15'h0001, 8'h81, 1'b0, '0},
      '{OP_PRG,   15'h0000, 8'h00, 1'b0, '0},
      '{OP_PRG,   15'h4000, 8'h00, 1'b0, '0},
      '{OP_PRG,   15'h2000, 8'h00, 1'b0, '0},
      '{OP_CHR,   15'h1000, 8'h00, 1'b0, '0},
      '{OP_CHR,   15'h0C00, 8'h00, 1'b0, '0},
      '{OP_WRITE, 15'h4000, 8'h02, 1'b0, '0},
      '{OP_WRITE, 15'h6001, 8'h00, 1'b0, '0},
      '{OP_WRITE, 15'h4001, 8'h00, 1'b0, '0},
      '{OP_TICK,  15'h0000, 8'h00, 1'b0, '0},
      '{OP_TICK,  15'h0000, 8'h00, 1'b0, '0},
      '{OP_TICK,  15'h0000, 8'h00, 1'b0, '0},
      '{OP_WRITE, 15'h6000, 8'h00, 1'b0, '0},
      '{OP_TICK,  15'h0000, 8'h00, 1'b0, '0}
   };

   localparam logic [8:0] PRG_SETTINGS [PHASE_COUNT] =
      '{9'd1, 9'd64, 9'd0, 9'h07F, 9'h1C5, 9'd37, 9'd2, 9'd0};
   localparam logic [8:0] CHR_SETTINGS [PHASE_COUNT] =
      '{9'd1, 9'd256, 9'd0, 9'h1FF, 9'd300, 9'd200, 9'd8, 9'd0};

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   opcode_type                  req_opcode = OP_WRITE;
   logic [ADDRESS_WIDTH-1:0]    req_address = '0;
   logic [DATA_WIDTH-1:0]       req_write_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [OFFSET_WIDTH-1:0]     rsp_rom_offset;
   logic                        rsp_mirror_horizontal;
   logic                        rsp_irq_request;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = CSR_PRG_COUNT;
   logic [CSR_DATA_WIDTH-1:0]   csr_write_data = '0;

   logic [6:0] prg_count_q;
   logic [8:0] chr_count_q;
   logic [2:0] select_q;
   logic       prg_mode_q;
   logic       chr_mode_q;
   logic [7:0] bank_q [8];
   logic [7:0] latch_q;
   logic [7:0] counter_q;
   logic       irq_enable_q;
   logic       reload_q;
   logic       mirror_q;

   outcome_type pending_outcomes [$];
   int       errors = 0;
   int       words_sent = 0;
   int       pending_gap = 0;
   bit       steady_sender = 1'b0;
   int       stall_left = 0;
   int       idle_cycles = 0;

   banked_rom_mapper_with_scanline_irq dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_address           (req_address),
      .req_write_data        (req_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_rom_offset        (rsp_rom_offset),
      .rsp_mirror_horizontal (rsp_mirror_horizontal),
      .rsp_irq_request       (rsp_irq_request),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_mapper_state();
      prg_count_q = PRG_COUNT_RESET;
      chr_count_q = CHR_COUNT_RESET;
      select_q = '0;
      prg_mode_q = 1'b0;
      chr_mode_q = 1'b0;
      for (int i = 0; i < 8; i++) bank_q[i] = '0;
      latch_q = '0;
      counter_q = '0;
      irq_enable_q = 1'b0;
      reload_q = 1'b0;
      mirror_q = 1'b1;
   endfunction

   function automatic outcome_type mapper_outcome(opcode_type op, logic [14:0] addr,
                                                  logic [7:0] data);
      outcome_type  o;
      int           n;
      int           bank;
      int           second_last;
      logic [12:0]  a;
      logic         upper_half;
      reg_code_type code;
      o = '0;
      case (op)
         OP_WRITE: begin
            code = reg_code_type'({addr[14:13], addr[0]});
            case (code)
               REG_SELECT: begin
                  select_q = data[2:0];
                  prg_mode_q = data[6];
                  chr_mode_q = data[7];
               end
               REG_BANK:    bank_q[select_q] = data;
               REG_MIRROR:  mirror_q = data[0];
               REG_LATCH:   latch_q = data;
               REG_RELOAD:  reload_q = 1'b1;
               REG_IRQ_OFF: irq_enable_q = 1'b0;
               REG_IRQ_ON:  irq_enable_q = 1'b1;
               default: ;
            endcase
         end
         OP_PRG: begin
            n = (prg_count_q == 0) ? 1 :
                (prg_count_q > PRG_COUNT_MAX) ? int'(PRG_COUNT_MAX) : int'(prg_count_q);
            second_last = (n - 2) & 255;
            case (addr[14:13])
               2'd0: bank = prg_mode_q ? second_last : int'(bank_q[6] & 8'h3F);
               2'd1: bank = int'(bank_q[7] & 8'h3F);
               2'd2: bank = prg_mode_q ? int'(bank_q[6] & 8'h3F) : second_last;
               default: bank = n - 1;
            endcase
            o.rom_offset = 19'((bank % n) * 32'h2000 + int'(addr[12:0]));
         end
         OP_CHR: begin
            n = (chr_count_q == 0) ? 1 :
                (chr_count_q > CHR_COUNT_MAX) ? int'(CHR_COUNT_MAX) : int'(chr_count_q);
            a = addr[12:0];
            upper_half = a[12] ^ chr_mode_q;
            if (!upper_half) begin
               bank = int'({bank_q[a[11]][7:1], a[10]});
            end else begin
               bank = int'(bank_q[2 + a[11:10]]);
            end
            o.rom_offset = 19'((bank % n) * 32'h400 + int'(a[9:0]));
         end
         default: begin
            if (counter_q == 0 || reload_q) begin
               counter_q = latch_q;
               reload_q = 1'b0;
            end else begin
               counter_q = counter_q - 8'd1;
            end
            o.irq_request = (counter_q == 0) && irq_enable_q;
         end
      endcase
      o.mirror_horizontal = mirror_q;
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [14:0] reg_address(reg_code_type code);
      logic [2:0] c;
      c = code;
      return {c[2:1], 12'($urandom), c[0]};
   endfunction

   task automatic send_word(opcode_type op, logic [14:0] addr, logic [7:0] data,
                            bit use_given = 1'b0, outcome_type given = '0);
      outcome_type predicted;
      repeat (pending_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_address <= addr;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
      predicted = mapper_outcome(op, addr, data);
      pending_outcomes.push_back(use_given ? given : predicted);
      words_sent++;
      pending_gap = steady_sender ? 0 : pick_gap();
      if (pending_gap > 0) req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      if (pending_gap == 0) req_valid <= 1'b0;
      pending_gap = 0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic program_counts(logic [8:0] prg_word, logic [8:0] chr_word);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_PRG_COUNT;
      csr_write_data <= prg_word;
      @(posedge clock);
      prg_count_q = prg_word[6:0];
      csr_index <= CSR_CHR_COUNT;
      csr_write_data <= chr_word;
      @(posedge clock);
      chr_count_q = chr_word;
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_scenario();
      int pick;
      int ticks;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         send_word(OP_WRITE, reg_address(REG_SELECT), 8'($urandom));
         send_word(OP_WRITE, reg_address(REG_BANK), 8'($urandom));
      end else if (pick < 28) begin
         send_word(OP_WRITE, reg_address(REG_LATCH),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)));
         send_word(OP_WRITE, reg_address(($urandom_range(0, 3) == 0) ? REG_IRQ_OFF
                                                                     : REG_IRQ_ON),
                   8'($urandom));
         if ($urandom_range(0, 1) == 1)
            send_word(OP_WRITE, reg_address(REG_RELOAD), 8'($urandom));
         ticks = $urandom_range(1, 10);
         for (int i = 0; i < ticks; i++) send_word(OP_TICK, 15'($urandom), 8'($urandom));
      end else if (pick < 40) begin
         send_word(OP_WRITE, 15'($urandom), 8'($urandom));
      end else if (pick < 45) begin
         send_word(OP_WRITE, reg_address(($urandom_range(0, 1) == 1) ? REG_MIRROR
                                                                     : REG_UNUSED),
                   8'($urandom));
      end else if (pick < 65) begin
         send_word(OP_PRG, 15'($urandom), 8'($urandom));
      end else if (pick < 85) begin
         send_word(OP_CHR, 15'($urandom), 8'($urandom));
      end else begin
         send_word(OP_TICK, 15'($urandom), 8'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= $urandom_range(0, 30);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result word with no expectation waiting");
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_rom_offset !== want.rom_offset) begin
               $error("rom_offset: expected 0x%0h, got 0x%0h", want.rom_offset, rsp_rom_offset);
               errors++;
            end
            if (rsp_mirror_horizontal !== want.mirror_horizontal) begin
               $error("mirror_horizontal: expected %0b, got %0b",
                      want.mirror_horizontal, rsp_mirror_horizontal);
               errors++;
            end
            if (rsp_irq_request !== want.irq_request) begin
               $error("irq_request: expected %0b, got %0b", want.irq_request, rsp_irq_request);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** banked_rom_mapper_with_scanline_irq: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int start;
      bit paused;
      reset_mapper_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_word(DIRECTED[i].op, DIRECTED[i].address, DIRECTED[i].data,
                   DIRECTED[i].typed, DIRECTED[i].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         program_counts((p == PHASE_COUNT - 1) ? 9'($urandom_range(1, 64)) : PRG_SETTINGS[p],
                        (p == PHASE_COUNT - 1) ? 9'($urandom_range(1, 256)) : CHR_SETTINGS[p]);
         steady_sender = (p % 3 == 2);
         start = words_sent;
         paused = 1'b0;
         while (words_sent - start < PHASE_WORDS) begin
            if (!paused && words_sent - start >= PHASE_WORDS / 2) begin
               drain_results();
               paused = 1'b1;
            end
            send_random_scenario();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d expected result words never arrived", pending_outcomes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("** banked_rom_mapper_with_scanline_irq: PASSED **");
      end else begin
         $display("** banked_rom_mapper_with_scanline_irq: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/bmap_pkg.sv
hdl/bmap_front.sv
hdl/bmap_queue.sv
hdl/bmap_back.sv
hdl/banked_rom_mapper_with_scanline_irq.sv
tb/banked_rom_mapper_with_scanline_irq_tb.sv
